/* hw/rtl/mbps_pkg.sv */
// shared constants and types for the masked byte pattern search unit
package mbps_pkg;

   localparam int NEEDLE_BYTES    = 16;
   localparam int BYTE_W          = 8;
   localparam int LEN_W           = 5;
   localparam int POS_W           = $clog2(NEEDLE_BYTES);
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 64;
   localparam int RSP_OFFSET_W    = 32;
   localparam int MAX_NEEDLE_DEF  = 16;
   localparam int OFFSET_BITS_DEF = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NEEDLE_LOW  = 3'd0,
      CSR_NEEDLE_HIGH = 3'd1,
      CSR_WILD_MASK   = 3'd2,
      CSR_NEEDLE_LEN  = 3'd3,
      CSR_FIRST_ONLY  = 3'd4
   } csr_index_type;

   // needle setup seen by every window cell
   typedef struct packed {
      logic [NEEDLE_BYTES-1:0][BYTE_W-1:0] needle;
      logic [NEEDLE_BYTES-1:0]             wild;
      logic [LEN_W-1:0]                    len;
   } pattern_type;

endpackage

/* hw/rtl/mbps_window_cell.sv */
// one window cell: holds a past byte, shifts it on, checks it against its needle position
module mbps_window_cell #(
   parameter int CELL_IDX = 0
) (
   input  logic                         clock,
   input  logic                         shift_en,
   input  logic [mbps_pkg::BYTE_W-1:0]  byte_in,
   input  mbps_pkg::pattern_type        pattern,
   output logic [mbps_pkg::BYTE_W-1:0]  byte_out,
   output logic                         hit
);
   import mbps_pkg::*;

   logic [BYTE_W-1:0] byte_ff;
   logic [LEN_W:0]    len_ext;
   logic [LEN_W:0]    pos_full;
   logic [POS_W-1:0]  pos;
   logic              active;

   // byte held here arrived CELL_IDX+1 requests ago
   always_ff @(posedge clock) begin
      if (shift_en) begin
         byte_ff <= byte_in;
      end
   end

   // needle position compared here is len-2-CELL_IDX, only when it exists
   always_comb begin
      len_ext  = {1'b0, pattern.len};
      active   = (len_ext >= (LEN_W+1)'(CELL_IDX + 2));
      pos_full = len_ext - (LEN_W+1)'(CELL_IDX + 2);
      pos      = pos_full[POS_W-1:0];
      hit      = !active || pattern.wild[pos] || (byte_ff == pattern.needle[pos]);
   end

   assign byte_out = byte_ff;

endmodule

/* hw/rtl/masked_byte_pattern_search_unit.sv */
// top level of the masked byte pattern search unit
// an accepted request's response is registered and shows in the output register in the next cycle
// throughput: one request per cycle unless a held response is not taken; the output register is the only stage
// reset clears config registers, scan counter, first-match flag and response valid
// the window cells hold no reset value; stale bytes are never used because the
// scan counter gates every compare
module masked_byte_pattern_search_unit #(
   parameter int MAX_NEEDLE  = mbps_pkg::MAX_NEEDLE_DEF,
   parameter int OFFSET_BITS = mbps_pkg::OFFSET_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [mbps_pkg::BYTE_W-1:0]         req_data_byte,
   input  logic                                req_last_byte,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_match_found,
   output logic [mbps_pkg::RSP_OFFSET_W-1:0]   rsp_match_offset,
   output logic                                rsp_pattern_error,
   output logic                                rsp_scan_end,
   // register write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mbps_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mbps_pkg::CSR_DATA_W-1:0]     csr_data
);
   import mbps_pkg::*;

   // config registers
   logic [CSR_DATA_W-1:0]    needle_low_ff;
   logic [CSR_DATA_W-1:0]    needle_high_ff;
   logic [NEEDLE_BYTES-1:0]  wild_mask_ff;
   logic [LEN_W-1:0]         needle_len_ff;
   logic                     first_only_ff;

   // scan state
   logic [OFFSET_BITS-1:0]   bytes_seen_ff;
   logic [OFFSET_BITS-1:0]   bytes_seen_in;
   logic                     reported_ff;
   logic                     reported_in;

   // response register
   logic                     rsp_valid_ff;
   logic                     found_ff;
   logic [RSP_OFFSET_W-1:0]  offset_ff;
   logic                     perr_ff;
   logic                     scan_end_ff;

   logic                     req_accept;
   logic                     perr;
   logic [LEN_W-1:0]         len_eff;
   logic [LEN_W-1:0]         len_m1;
   logic [POS_W-1:0]         pos_last;
   pattern_type              pattern;
   logic [MAX_NEEDLE-1:0]    hits;
   logic                     seen_ok;
   logic                     found;
   logic [OFFSET_BITS-1:0]   offset;
   logic [RSP_OFFSET_W-1:0]  offset_rsp;
   logic [MAX_NEEDLE-1:0][BYTE_W-1:0] taps;

   // handshakes: response register frees up in the same cycle it is taken
   assign csr_ready  = 1'b1;
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   // register writes, unknown indexes fall through
   always_ff @(posedge clock) begin
      if (reset) begin
         needle_low_ff  <= '0;
         needle_high_ff <= '0;
         wild_mask_ff   <= '0;
         needle_len_ff  <= '0;
         first_only_ff  <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_NEEDLE_LOW:  needle_low_ff  <= csr_data;
            CSR_NEEDLE_HIGH: needle_high_ff <= csr_data;
            CSR_WILD_MASK:   wild_mask_ff   <= csr_data[NEEDLE_BYTES-1:0];
            CSR_NEEDLE_LEN:  needle_len_ff  <= csr_data[LEN_W-1:0];
            CSR_FIRST_ONLY:  first_only_ff  <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // overlong length behaves as the longest supported needle
   always_comb begin
      if (needle_len_ff > LEN_W'(MAX_NEEDLE)) begin
         len_eff = LEN_W'(MAX_NEEDLE);
      end else begin
         len_eff = needle_len_ff;
      end
      len_m1   = len_eff - LEN_W'(1);
      pos_last = len_m1[POS_W-1:0];
      perr     = wild_mask_ff[0];

      pattern.needle = {needle_high_ff, needle_low_ff};
      pattern.wild   = wild_mask_ff;
      pattern.len    = len_eff;
   end

   // window chain: tap 0 is the incoming byte, cell k holds the byte k+1 back
   assign taps[0] = req_data_byte;

   for (genvar k = 0; k < MAX_NEEDLE - 1; k++) begin : g_cell
      mbps_window_cell #(
         .CELL_IDX (k)
      ) u_cell (
         .clock    (clock),
         .shift_en (req_accept),
         .byte_in  (taps[k]),
         .pattern  (pattern),
         .byte_out (taps[k+1]),
         .hit      (hits[k])
      );
   end

   // last needle position always lines up with the incoming byte
   assign hits[MAX_NEEDLE-1] = pattern.wild[pos_last] ||
                               (req_data_byte == pattern.needle[pos_last]);

   // match decision: no pattern error, nonzero length, enough bytes seen, every position agrees, first-only gate
   always_comb begin
      seen_ok = (bytes_seen_ff >= OFFSET_BITS'(len_m1));
      found   = !perr && (len_eff != '0) && seen_ok && (&hits) &&
                !(first_only_ff && reported_ff);
      offset  = found ? (bytes_seen_ff - OFFSET_BITS'(len_m1)) : '0;
   end

   if (OFFSET_BITS >= RSP_OFFSET_W) begin : g_off_trunc
      assign offset_rsp = offset[RSP_OFFSET_W-1:0];
   end else begin : g_off_ext
      assign offset_rsp = {{(RSP_OFFSET_W-OFFSET_BITS){1'b0}}, offset};
   end

   // scan state: counter saturates, everything clears after the last byte
   always_comb begin
      bytes_seen_in = bytes_seen_ff;
      reported_in   = reported_ff;
      if (req_accept) begin
         if (req_last_byte) begin
            bytes_seen_in = '0;
            reported_in   = 1'b0;
         end else begin
            if (!(&bytes_seen_ff)) begin
               bytes_seen_in = bytes_seen_ff + OFFSET_BITS'(1);
            end
            reported_in = reported_ff || found;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff <= '0;
         reported_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         bytes_seen_ff <= bytes_seen_in;
         reported_ff   <= reported_in;
         if (req_accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload, loaded with each accepted request
   always_ff @(posedge clock) begin
      if (req_accept) begin
         found_ff    <= found;
         offset_ff   <= offset_rsp;
         perr_ff     <= perr;
         scan_end_ff <= req_last_byte;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_match_found   = found_ff;
   assign rsp_match_offset  = offset_ff;
   assign rsp_pattern_error = perr_ff;
   assign rsp_scan_end      = scan_end_ff;

endmodule
